### hw/rtl/srov_pkg.sv
package srov_pkg;

  // sizes
  localparam int OLD_POINTS_MAX = 4096;
  localparam int NEW_POINTS_MAX = 4096;
  localparam int ADDR_W         = 12;
  localparam int CNT_W          = 13;
  localparam int IDX_W          = 14;
  localparam int POS_W          = 32;
  localparam int COUNT_W        = 32;
  localparam int EDGE_W         = 40;
  localparam int FRAC_BITS      = 24;
  localparam int SUM_W          = 48;
  localparam int STAT_W         = 3;
  localparam int DCNT_W         = 5;

  // request commands
  localparam logic [1:0] CMD_LOAD_OLD = 2'd0;
  localparam logic [1:0] CMD_LOAD_NEW = 2'd1;
  localparam logic [1:0] CMD_COMPUTE  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FEW_OLD  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FEW_NEW  = 3'd2;
  localparam logic [STAT_W-1:0] ST_OLD_FLAT = 3'd3;
  localparam logic [STAT_W-1:0] ST_NEW_FLAT = 3'd4;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CHECK,
    OP_RD_A,
    OP_RD_B,
    OP_RD_C,
    OP_RD_D,
    OP_RD_E,
    OP_EDGES,
    OP_SET_ABOVE,
    OP_SRCH_INIT,
    OP_SRCH_RD,
    OP_SRCH_UPD,
    OP_PICK,
    OP_E1,
    OP_E2,
    OP_E3,
    OP_E4,
    OP_SETUP,
    OP_DIV,
    OP_MUL,
    OP_ACC,
    OP_SUM_INIT,
    OP_SUM_RD,
    OP_SUM_ACC,
    OP_FINISH
  } op_t;

  // kind of edge share
  typedef enum logic [1:0] {
    SH_ZERO,
    SH_WHOLE,
    SH_DIV
  } share_kind_t;

  typedef struct packed {
    op_t  op;
    logic accept;
    logic side;
  } ctl_t;

  typedef struct packed {
    logic        err;
    logic        beyond;
    logic        above;
    logic        in_range;
    logic        more;
    share_kind_t kind;
    logic        div_last;
    logic        sum_more;
  } stat_t;

endpackage

### hw/rtl/srov_ctrl.sv
module srov_ctrl
  import srov_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] cmd,
  output logic       res_valid,
  input  logic       res_stall,
  output ctl_t       ctl,
  input  stat_t      st
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_DECIDE,
    S_RD_A,
    S_RD_B,
    S_RD_C,
    S_RD_D,
    S_RD_E,
    S_EDGES,
    S_SIDE,
    S_NEXT_SIDE,
    S_SRCH_CHK,
    S_SRCH_RD,
    S_SRCH_UPD,
    S_E1,
    S_E2,
    S_E3,
    S_E4,
    S_SETUP,
    S_KIND,
    S_DIV,
    S_MUL,
    S_ACC,
    S_SUM_INIT,
    S_SUM_CHK,
    S_SUM_RD,
    S_SUM_ACC,
    S_DONE
  } state_t;

  state_t state;
  logic   side;
  logic   out_free;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !(res_valid && res_stall);

  // operation for the current step
  always_comb begin
    ctl.accept = req_valid && (state == S_IDLE);
    ctl.side   = side;
    unique case (state)
      S_CHECK:     ctl.op = OP_CHECK;
      S_RD_A:      ctl.op = OP_RD_A;
      S_RD_B:      ctl.op = OP_RD_B;
      S_RD_C:      ctl.op = OP_RD_C;
      S_RD_D:      ctl.op = OP_RD_D;
      S_RD_E:      ctl.op = OP_RD_E;
      S_EDGES:     ctl.op = OP_EDGES;
      S_SIDE: begin
        if (st.above) ctl.op = OP_SET_ABOVE;
        else if (st.in_range) ctl.op = OP_SRCH_INIT;
        else ctl.op = OP_NONE;
      end
      S_SRCH_CHK:  ctl.op = st.more ? OP_NONE : OP_PICK;
      S_SRCH_RD:   ctl.op = OP_SRCH_RD;
      S_SRCH_UPD:  ctl.op = OP_SRCH_UPD;
      S_E1:        ctl.op = OP_E1;
      S_E2:        ctl.op = OP_E2;
      S_E3:        ctl.op = OP_E3;
      S_E4:        ctl.op = OP_E4;
      S_SETUP:     ctl.op = OP_SETUP;
      S_DIV:       ctl.op = OP_DIV;
      S_MUL:       ctl.op = OP_MUL;
      S_ACC:       ctl.op = OP_ACC;
      S_SUM_INIT:  ctl.op = OP_SUM_INIT;
      S_SUM_RD:    ctl.op = OP_SUM_RD;
      S_SUM_ACC:   ctl.op = OP_SUM_ACC;
      S_DONE:      ctl.op = out_free ? OP_FINISH : OP_NONE;
      default:     ctl.op = OP_NONE;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      side      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // result register
      if (state == S_DONE && out_free) res_valid <= 1'b1;
      else if (res_valid && !res_stall) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_valid && cmd == CMD_COMPUTE) state <= S_CHECK;
        end
        S_CHECK: state <= S_DECIDE;
        S_DECIDE: begin
          if (st.err) state <= S_DONE;
          else if (st.beyond) state <= S_IDLE;
          else state <= S_RD_A;
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: state <= S_RD_C;
        S_RD_C: state <= S_RD_D;
        S_RD_D: state <= S_RD_E;
        S_RD_E: state <= S_EDGES;
        S_EDGES: begin
          side  <= 1'b0;
          state <= S_SIDE;
        end
        S_SIDE: begin
          if (!st.above && st.in_range) state <= S_SRCH_CHK;
          else state <= S_NEXT_SIDE;
        end
        S_NEXT_SIDE: begin
          if (!side) begin
            side  <= 1'b1;
            state <= S_SIDE;
          end else begin
            state <= S_SUM_INIT;
          end
        end
        S_SRCH_CHK: state <= st.more ? S_SRCH_RD : S_E1;
        S_SRCH_RD:  state <= S_SRCH_UPD;
        S_SRCH_UPD: state <= S_SRCH_CHK;
        S_E1:       state <= S_E2;
        S_E2:       state <= S_E3;
        S_E3:       state <= S_E4;
        S_E4:       state <= S_SETUP;
        S_SETUP:    state <= S_KIND;
        S_KIND:     state <= (st.kind == SH_DIV) ? S_DIV : S_ACC;
        S_DIV: begin
          if (st.div_last) state <= S_MUL;
        end
        S_MUL:      state <= S_ACC;
        S_ACC:      state <= S_NEXT_SIDE;
        S_SUM_INIT: state <= S_SUM_CHK;
        S_SUM_CHK:  state <= st.sum_more ? S_SUM_RD : S_DONE;
        S_SUM_RD:   state <= S_SUM_ACC;
        S_SUM_ACC:  state <= S_SUM_CHK;
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/srov_datapath.sv
module srov_datapath
  import srov_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic                      cfg_index,
  input  logic [CNT_W-1:0]          cfg_data,
  input  logic [1:0]                cmd,
  input  logic [ADDR_W-1:0]         point_index,
  input  logic signed [POS_W-1:0]   position,
  input  logic [COUNT_W-1:0]        count_in,
  input  ctl_t                      ctl,
  output stat_t                     st,
  output logic [ADDR_W-1:0]         bin_number,
  output logic [SUM_W-1:0]          rebinned_count,
  output logic [STAT_W-1:0]         status
);

  // memories
  logic signed [POS_W-1:0]   old_c_mem [OLD_POINTS_MAX];
  logic [COUNT_W-1:0]        old_n_mem [OLD_POINTS_MAX];
  logic signed [POS_W-1:0]   new_c_mem [NEW_POINTS_MAX];
  logic signed [POS_W-1:0]   rd_oc;
  logic [COUNT_W-1:0]        rd_on;
  logic signed [POS_W-1:0]   rd_nc;
  logic [ADDR_W-1:0]         old_addr;
  logic [ADDR_W-1:0]         new_addr;
  logic                      wr_old;
  logic                      wr_new;

  // configuration and shadows of the first two centres
  logic [CNT_W-1:0]          old_cfg;
  logic [CNT_W-1:0]          new_cfg;
  logic [CNT_W-1:0]          n_old;
  logic [CNT_W-1:0]          n_new;
  logic signed [POS_W-1:0]   c_old0, c_old1, c_new0, c_new1;

  // work registers
  logic [ADDR_W-1:0]         k;
  logic [STAT_W-1:0]         stat_code;
  logic signed [POS_W-1:0]   top1, top2, nk, nkm, cm, cc;
  logic signed [EDGE_W-1:0]  lo_old, hi_old, lo_k, hi_k, ea, eb;
  logic [ADDR_W-1:0]         s_lo, s_hi, isel;
  logic signed [POS_W-1:0]   v_lo, v_hi;
  logic signed [IDX_W-1:0]   i_lo, i_hi, j;
  logic [COUNT_W-1:0]        y;
  logic [EDGE_W-1:0]         rem, den_r;
  logic [FRAC_BITS-1:0]      quo;
  logic [DCNT_W-1:0]         dcnt;
  share_kind_t               kind;
  logic                      replace;
  logic [COUNT_W-1:0]        share_val;
  logic [SUM_W-1:0]          sum;

  // combinational helpers
  logic [CNT_W-1:0]          mid_sum;
  logic [ADDR_W-1:0]         mid;
  logic signed [EDGE_W-1:0]  t;
  logic signed [EDGE_W-1:0]  lo_k_c, hi_k_c;
  logic signed [EDGE_W-1:0]  num_c, den_c;
  logic signed [EDGE_W-1:0]  d_lo, d_hi;
  logic [EDGE_W-1:0]         rem2;
  logic [55:0]               prod;
  logic signed [IDX_W-1:0]   n_old_x;

  function automatic logic signed [EDGE_W-1:0] outer_edge(
    input logic signed [POS_W-1:0] c_end,
    input logic signed [POS_W-1:0] c_in
  );
    logic signed [EDGE_W-1:0] e;
    logic signed [EDGE_W-1:0] i;
    e = EDGE_W'(c_end);
    i = EDGE_W'(c_in);
    return (e <<< 1) + e - i;
  endfunction

  function automatic logic signed [EDGE_W-1:0] absval(input logic signed [EDGE_W-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

  assign n_old   = (old_cfg > CNT_W'(OLD_POINTS_MAX)) ? CNT_W'(OLD_POINTS_MAX) : old_cfg;
  assign n_new   = (new_cfg > CNT_W'(NEW_POINTS_MAX)) ? CNT_W'(NEW_POINTS_MAX) : new_cfg;
  assign n_old_x = IDX_W'(n_old);
  assign wr_old  = ctl.accept && (cmd == CMD_LOAD_OLD);
  assign wr_new  = ctl.accept && (cmd == CMD_LOAD_NEW);

  // search midpoint and target edge of the current side
  assign mid_sum = {1'b0, s_lo} + {1'b0, s_hi};
  assign mid     = mid_sum[CNT_W-1:1];
  assign t       = ctl.side ? hi_k : lo_k;

  // new bin edges, doubled
  assign lo_k_c = (k != '0) ? EDGE_W'(nkm) + EDGE_W'(nk) : outer_edge(c_new0, c_new1);
  assign hi_k_c = ({1'b0, k} < n_new - CNT_W'(1)) ? EDGE_W'(nk) + EDGE_W'(rd_nc)
                                                  : outer_edge(nk, nkm);

  // overlap fraction terms
  assign num_c = ctl.side ? ((i_hi == i_lo) ? hi_k - lo_k : hi_k - ea) : eb - lo_k;
  assign den_c = eb - ea;

  assign d_lo = absval((EDGE_W'(v_lo) <<< 1) - t);
  assign d_hi = absval((EDGE_W'(v_hi) <<< 1) - t);
  assign rem2 = {rem[EDGE_W-2:0], 1'b0};
  assign prod = 56'(y) * 56'(quo);

  // memory address select
  always_comb begin
    unique case (ctl.op)
      OP_RD_A:    old_addr = ADDR_W'(n_old - CNT_W'(1));
      OP_RD_B:    old_addr = ADDR_W'(n_old - CNT_W'(2));
      OP_SRCH_RD: old_addr = mid;
      OP_E1:      old_addr = isel - ADDR_W'(1);
      OP_E2:      old_addr = isel;
      OP_E3:      old_addr = isel + ADDR_W'(1);
      OP_SUM_RD:  old_addr = j[ADDR_W-1:0];
      default:    old_addr = isel;
    endcase
    unique case (ctl.op)
      OP_RD_D: new_addr = k - ADDR_W'(1);
      OP_RD_E: new_addr = k + ADDR_W'(1);
      default: new_addr = k;
    endcase
  end

  // memories, registered reads
  always_ff @(posedge clk) begin
    if (wr_old) begin
      old_c_mem[point_index] <= position;
      old_n_mem[point_index] <= count_in;
    end
    if (wr_new) new_c_mem[point_index] <= position;
    rd_oc <= old_c_mem[old_addr];
    rd_on <= old_n_mem[old_addr];
    rd_nc <= new_c_mem[new_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      old_cfg <= '0;
      new_cfg <= '0;
    end else if (cfg_valid) begin
      if (cfg_index) new_cfg <= cfg_data;
      else old_cfg <= cfg_data;
    end
  end

  // status to the controller
  always_comb begin
    st.err      = (stat_code != ST_OK);
    st.beyond   = ({1'b0, k} >= n_new);
    st.above    = (t >= hi_old);
    st.in_range = ctl.side ? (hi_k > lo_old) : (lo_k >= lo_old);
    st.more     = ((s_hi - s_lo) > ADDR_W'(1));
    st.kind     = kind;
    st.div_last = (dcnt == DCNT_W'(FRAC_BITS - 1));
    st.sum_more = (j < i_hi);
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      k <= point_index;
      if (wr_old && point_index == ADDR_W'(0)) c_old0 <= position;
      if (wr_old && point_index == ADDR_W'(1)) c_old1 <= position;
      if (wr_new && point_index == ADDR_W'(0)) c_new0 <= position;
      if (wr_new && point_index == ADDR_W'(1)) c_new1 <= position;
    end
    unique case (ctl.op)
      OP_CHECK: begin
        sum  <= '0;
        i_lo <= -IDX_W'(1);
        i_hi <= -IDX_W'(1);
        if (n_old < CNT_W'(2)) stat_code <= ST_FEW_OLD;
        else if (n_new < CNT_W'(2)) stat_code <= ST_FEW_NEW;
        else if (c_old1 <= c_old0) stat_code <= ST_OLD_FLAT;
        else if (c_new1 <= c_new0) stat_code <= ST_NEW_FLAT;
        else stat_code <= ST_OK;
      end
      OP_RD_B: top1 <= rd_oc;
      OP_RD_C: top2 <= rd_oc;
      OP_RD_D: nk   <= rd_nc;
      OP_RD_E: nkm  <= rd_nc;
      OP_EDGES: begin
        lo_old <= outer_edge(c_old0, c_old1);
        hi_old <= outer_edge(top1, top2);
        lo_k   <= lo_k_c;
        hi_k   <= hi_k_c;
      end
      OP_SET_ABOVE: begin
        if (ctl.side) i_hi <= n_old_x;
        else i_lo <= n_old_x;
      end
      OP_SRCH_INIT: begin
        s_lo <= '0;
        s_hi <= ADDR_W'(n_old - CNT_W'(1));
        v_lo <= c_old0;
        v_hi <= top1;
      end
      OP_SRCH_UPD: begin
        if ((EDGE_W'(rd_oc) <<< 1) < t) begin
          s_lo <= mid;
          v_lo <= rd_oc;
        end else begin
          s_hi <= mid;
          v_hi <= rd_oc;
        end
      end
      OP_PICK: begin
        isel <= (d_lo < d_hi) ? s_lo : s_hi;
        if (ctl.side) i_hi <= (d_lo < d_hi) ? IDX_W'(s_lo) : IDX_W'(s_hi);
        else i_lo <= (d_lo < d_hi) ? IDX_W'(s_lo) : IDX_W'(s_hi);
      end
      OP_E2: cm <= rd_oc;
      OP_E3: begin
        cc <= rd_oc;
        y  <= rd_on;
      end
      OP_E4: begin
        ea <= (isel != '0) ? EDGE_W'(cm) + EDGE_W'(cc) : lo_old;
        eb <= ({1'b0, isel} < n_old - CNT_W'(1)) ? EDGE_W'(cc) + EDGE_W'(rd_oc) : hi_old;
      end
      OP_SETUP: begin
        replace <= ctl.side && (i_hi == i_lo);
        rem     <= num_c;
        den_r   <= den_c;
        quo     <= '0;
        dcnt    <= '0;
        if (den_c <= 0 || num_c <= 0) begin
          kind      <= SH_ZERO;
          share_val <= '0;
        end else if (num_c >= den_c) begin
          kind      <= SH_WHOLE;
          share_val <= y;
        end else begin
          kind      <= SH_DIV;
          share_val <= '0;
        end
      end
      // one quotient bit per step
      OP_DIV: begin
        dcnt <= dcnt + DCNT_W'(1);
        if (rem2 >= den_r) begin
          rem <= rem2 - den_r;
          quo <= {quo[FRAC_BITS-2:0], 1'b1};
        end else begin
          rem <= rem2;
          quo <= {quo[FRAC_BITS-2:0], 1'b0};
        end
      end
      OP_MUL: share_val <= prod[55:FRAC_BITS];
      OP_ACC: sum <= (replace ? '0 : sum) + SUM_W'(share_val);
      OP_SUM_INIT: j <= i_lo + IDX_W'(1);
      OP_SUM_RD:   j <= j + IDX_W'(1);
      OP_SUM_ACC:  sum <= sum + SUM_W'(rd_on);
      OP_FINISH: begin
        bin_number     <= k;
        rebinned_count <= (stat_code != ST_OK) ? '0 : sum;
        status         <= stat_code;
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/spectrum_rebin_overlap_top.sv
// loads (cmd 0, 1) and cmd 3 are taken in idle and keep the block idle; a compute request
// reads the edges, searches the old centres for each edge inside the old range (at most
// ceil(log2(n_old)) search steps), runs the 24-step divider when a share needs it, adds
// each whole old bin; an error result skips the memory reads, and a bin beyond the new
// data gives no result. one request is worked at a time; sync active-high reset clears
// counts and control; memories undefined until loaded
module spectrum_rebin_overlap_top
  import srov_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [CNT_W-1:0]         cfg_data,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic [1:0]               cmd,
  input  logic [ADDR_W-1:0]        point_index,
  input  logic signed [POS_W-1:0]  position,
  input  logic [COUNT_W-1:0]       count_in,
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic [ADDR_W-1:0]        bin_number,
  output logic [SUM_W-1:0]         rebinned_count,
  output logic [STAT_W-1:0]        status
);

  ctl_t  ctl;
  stat_t st;

  assign cfg_ready = 1'b1;

  srov_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .ctl       (ctl),
    .st        (st)
  );

  srov_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .point_index    (point_index),
    .position       (position),
    .count_in       (count_in),
    .ctl            (ctl),
    .st             (st),
    .bin_number     (bin_number),
    .rebinned_count (rebinned_count),
    .status         (status)
  );

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import srov_pkg::*;

  // configuration register indexes
  localparam logic REG_OLD_COUNT = 1'b0;
  localparam logic REG_NEW_COUNT = 1'b1;
  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam longint unsigned COUNT_LIMIT = 48'hFFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [1:0]               op;
    logic [ADDR_W-1:0]        idx;
    logic signed [POS_W-1:0]  pos;
    logic [COUNT_W-1:0]       cnt;
  } rebin_req_t;

  typedef struct {
    logic [ADDR_W-1:0] bin;
    logic [SUM_W-1:0]  cnt;
    logic [STAT_W-1:0] st;
  } bin_result_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic                    cfg_index = 1'b0;
  logic [CNT_W-1:0]        cfg_data = '0;
  logic                    req_valid = 1'b0;
  logic                    req_stall;
  logic [1:0]              cmd = '0;
  logic [ADDR_W-1:0]       point_index = '0;
  logic signed [POS_W-1:0] position = '0;
  logic [COUNT_W-1:0]      count_in = '0;
  logic                    res_valid;
  logic                    res_stall = 1'b0;
  logic [ADDR_W-1:0]       bin_number;
  logic [SUM_W-1:0]        rebinned_count;
  logic [STAT_W-1:0]       status;

  spectrum_rebin_overlap_top dut (.*);

  // shadow of the block state
  logic signed [POS_W-1:0] old_pos_mem [OLD_POINTS_MAX];
  logic [COUNT_W-1:0]      old_cnt_mem [OLD_POINTS_MAX];
  logic signed [POS_W-1:0] new_pos_mem [NEW_POINTS_MAX];
  int unsigned             old_count_reg = 0;
  int unsigned             new_count_reg = 0;

  rebin_req_t  pending_reqs [$];
  bin_result_t expected_bins [$];
  rebin_req_t  next_req;
  bin_result_t seen_bin;
  int          snd_idle = 0;
  int          rcv_idle = 0;
  int          err_count = 0;
  int          cycle = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want, cycle);
    err_count++;
  endtask

  function automatic longint old_at(int i);
    return longint'(old_pos_mem[i]);
  endfunction

  function automatic longint new_at(int i);
    return longint'(new_pos_mem[i]);
  endfunction

  // floor(y * num / den) through a 24-bit fraction clamped to [0,1]
  function automatic longint unsigned overlap_share(logic [31:0] y, longint num, longint den);
    longint unsigned f;
    if (den <= 0 || num <= 0) return 0;
    if (num >= den) return longint'(y);
    f = (num * 64'sd16777216) / den;
    return ((64'(y)) * f) >> FRAC_BITS;
  endfunction

  // old centre nearest to a doubled position
  function automatic int nearest_old_bin(longint t, int n);
    int lo, hi, mid;
    longint dl, dh;
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (2 * old_at(mid) < t) lo = mid;
      else hi = mid;
    end
    dl = 2 * old_at(lo) - t;
    dh = 2 * old_at(hi) - t;
    if (dl < 0) dl = -dl;
    if (dh < 0) dh = -dh;
    return (dl < dh) ? lo : hi;
  endfunction

  function automatic longint old_low_edge(int i, longint lo_old);
    if (i > 0) return old_at(i - 1) + old_at(i);
    return lo_old;
  endfunction

  function automatic longint old_high_edge(int i, int n, longint hi_old);
    if (i < n - 1) return old_at(i) + old_at(i + 1);
    return hi_old;
  endfunction

  function automatic longint unsigned rebinned_sum(int k, int no, int nn);
    longint lo_old, hi_old, lo_k, hi_k, a, b;
    int i_lo, i_hi;
    longint unsigned sum;
    lo_old = 3 * old_at(0) - old_at(1);
    hi_old = 3 * old_at(no - 1) - old_at(no - 2);
    i_lo = -1;
    i_hi = -1;
    sum = 0;
    if (k > 0) lo_k = new_at(k - 1) + new_at(k);
    else lo_k = 3 * new_at(0) - new_at(1);
    if (k < nn - 1) hi_k = new_at(k) + new_at(k + 1);
    else hi_k = 3 * new_at(k) - new_at(k - 1);
    // low edge bin
    if (lo_k >= hi_old) begin
      i_lo = no;
    end else if (lo_k >= lo_old) begin
      i_lo = nearest_old_bin(lo_k, no);
      a = old_low_edge(i_lo, lo_old);
      b = old_high_edge(i_lo, no, hi_old);
      sum += overlap_share(old_cnt_mem[i_lo], b - lo_k, b - a);
    end
    // high edge bin, or a single proportional share
    if (hi_k >= hi_old) begin
      i_hi = no;
    end else if (hi_k > lo_old) begin
      i_hi = nearest_old_bin(hi_k, no);
      a = old_low_edge(i_hi, lo_old);
      b = old_high_edge(i_hi, no, hi_old);
      if (i_hi == i_lo) sum = overlap_share(old_cnt_mem[i_hi], hi_k - lo_k, b - a);
      else sum += overlap_share(old_cnt_mem[i_hi], hi_k - a, b - a);
    end
    // whole bins between the edges
    for (int i = i_lo + 1; i <= i_hi - 1; i++) sum += old_cnt_mem[i];
    return (sum > COUNT_LIMIT) ? COUNT_LIMIT : sum;
  endfunction

  // update the shadow state for an accepted request and queue its result
  task automatic predict_request(rebin_req_t r);
    int no, nn;
    bin_result_t e;
    no = (old_count_reg > OLD_POINTS_MAX) ? OLD_POINTS_MAX : old_count_reg;
    nn = (new_count_reg > NEW_POINTS_MAX) ? NEW_POINTS_MAX : new_count_reg;
    e.bin = r.idx;
    e.cnt = '0;
    e.st = ST_OK;
    case (r.op)
      CMD_LOAD_OLD: begin
        old_pos_mem[r.idx] = r.pos;
        old_cnt_mem[r.idx] = r.cnt;
      end
      CMD_LOAD_NEW: new_pos_mem[r.idx] = r.pos;
      CMD_COMPUTE: begin
        if (no < 2) e.st = ST_FEW_OLD;
        else if (nn < 2) e.st = ST_FEW_NEW;
        else if (old_pos_mem[1] <= old_pos_mem[0]) e.st = ST_OLD_FLAT;
        else if (new_pos_mem[1] <= new_pos_mem[0]) e.st = ST_NEW_FLAT;
        else if (int'(r.idx) < nn) e.cnt = rebinned_sum(int'(r.idx), no, nn);
        if (e.st != ST_OK || int'(r.idx) < nn) expected_bins.push_back(e);
      end
      default: ;
    endcase
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall)
        predict_request('{cmd, point_index, position, count_in});
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= snd_idle) begin
          next_req = pending_reqs.pop_front();
          req_valid <= 1'b1;
          cmd <= next_req.op;
          point_index <= next_req.idx;
          position <= next_req.pos;
          count_in <= next_req.cnt;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_bins.size() == 0) begin
          report_mismatch("unexpected result bin", bin_number, 0);
        end else begin
          seen_bin = expected_bins.pop_front();
          if (bin_number !== seen_bin.bin)
            report_mismatch("bin_number", bin_number, seen_bin.bin);
          if (rebinned_count !== seen_bin.cnt)
            report_mismatch("rebinned_count", rebinned_count, seen_bin.cnt);
          if (status !== seen_bin.st)
            report_mismatch("status", status, seen_bin.st);
        end
      end
      res_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_req(logic [1:0] op, int idx, logic [31:0] pos, logic [31:0] cnt);
    pending_reqs.push_back('{op, idx[ADDR_W-1:0], pos, cnt});
  endtask

  function automatic int drain_cycles();
    int n;
    n = (old_count_reg > OLD_POINTS_MAX) ? OLD_POINTS_MAX : old_count_reg;
    return 30 + 2 * (3 * 13 + 34) + 3 * n + 64;
  endfunction

  // wait until every request is taken and every result has come back
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || req_valid || expected_bins.size() != 0)
      @(posedge clk);
    repeat (drain_cycles()) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CNT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_OLD_COUNT) old_count_reg = value;
    else new_count_reg = value;
  endtask

  function automatic logic [31:0] random_count();
    case ($urandom_range(3))
      0: return 32'd0;
      1: return $urandom_range(0, 4096);
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // load n centres: grid, wide steps, or unsorted noise
  task automatic load_centres(logic [1:0] op, int n, int style, int smax);
    longint p;
    int step;
    if (style == 0) p = (longint'($urandom_range(0, 64)) - 32) <<< 16;
    else p = -longint'($urandom_range(0, 1 << 30));
    step = $urandom_range(1, 3) << 15;
    for (int i = 0; i < n; i++) begin
      if (style == 2) push_req(op, i, $urandom, random_count());
      else push_req(op, i, p[31:0], random_count());
      if (style == 0) p += step * $urandom_range(1, 2);
      else p += $urandom_range(1, smax);
    end
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin snd_idle = 20; rcv_idle = 52; end
      1: begin snd_idle = 52; rcv_idle = 20; end
      default: begin snd_idle = 0; rcv_idle = 0; end
    endcase
  endtask

  initial begin
    int no, nn, style, roll;
    set_idling(0);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // too few points, no memory reads
    write_reg(REG_OLD_COUNT, 13'd0);
    write_reg(REG_NEW_COUNT, 13'd0);
    push_req(CMD_COMPUTE, 0, 0, 0);
    wait_idle();
    write_reg(REG_OLD_COUNT, 13'h1FFF);
    write_reg(REG_NEW_COUNT, 13'd1);
    push_req(CMD_COMPUTE, 4095, 0, 0);
    wait_idle();

    // four points with extreme positions and counts
    write_reg(REG_OLD_COUNT, 13'd4);
    write_reg(REG_NEW_COUNT, 13'd4);
    push_req(CMD_LOAD_OLD, 0, 32'h8000_0000, 32'hFFFF_FFFF);
    push_req(CMD_LOAD_OLD, 1, -32'sd65536, 32'd0);
    push_req(CMD_LOAD_OLD, 2, 32'd65536, 32'h100);
    push_req(CMD_LOAD_OLD, 3, 32'h7FFF_FFFF, 32'h1234_5678);
    push_req(CMD_LOAD_NEW, 0, -32'sd1073741824, 0);
    push_req(CMD_LOAD_NEW, 1, 0, 0);
    push_req(CMD_LOAD_NEW, 2, 32'd536870912, 0);
    push_req(CMD_LOAD_NEW, 3, 32'd1073741824, 0);
    for (int k = 0; k < 4; k++) push_req(CMD_COMPUTE, k, 0, 0);
    // bins beyond the new data, ignored command
    push_req(CMD_COMPUTE, 4, 0, 0);
    push_req(CMD_COMPUTE, 4095, 0, 0);
    push_req(CMD_IGNORED, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // first two centres not rising
    push_req(CMD_LOAD_OLD, 1, 32'h8000_0000, 32'd7);
    push_req(CMD_COMPUTE, 1, 0, 0);
    push_req(CMD_LOAD_OLD, 1, -32'sd65536, 32'd7);
    push_req(CMD_LOAD_NEW, 1, -32'sd1073741824, 0);
    push_req(CMD_COMPUTE, 2, 0, 0);
    // new edges equal to the old edges, upper limit among them
    for (int i = 0; i < 4; i++) push_req(CMD_LOAD_NEW, i, (i - 1) * 32'sd131072, 0);
    for (int i = 0; i < 4; i++)
      push_req(CMD_LOAD_OLD, i, (i - 1) * 32'sd131072, 32'd1000 + i);
    for (int k = 0; k < 4; k++) push_req(CMD_COMPUTE, k, 0, 0);
    wait_idle();

    // a longer set of points, deeper searches and longer whole-bin sums
    load_centres(CMD_LOAD_OLD, 64, 1, 1 << 18);
    load_centres(CMD_LOAD_NEW, 64, 1, 1 << 18);
    wait_idle();
    write_reg(REG_OLD_COUNT, 13'd64);
    write_reg(REG_NEW_COUNT, 13'd64);
    push_req(CMD_COMPUTE, 0, 0, 0);
    push_req(CMD_COMPUTE, 63, 0, 0);
    repeat (4) push_req(CMD_COMPUTE, $urandom_range(0, 63), 0, 0);
    wait_idle();

    // random sets, mostly well formed
    for (int ph = 0; ph < 15; ph++) begin
      set_idling(ph / 5);
      no = ($urandom_range(9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
      nn = ($urandom_range(9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
      write_reg(REG_OLD_COUNT, CNT_W'(no));
      write_reg(REG_NEW_COUNT, CNT_W'(nn));
      roll = $urandom_range(9);
      style = (roll == 0) ? 2 : (roll < 5) ? 0 : 1;
      load_centres(CMD_LOAD_OLD, no, style, 1 << 24);
      roll = $urandom_range(9);
      style = (roll == 0) ? 2 : (roll < 5) ? 0 : 1;
      load_centres(CMD_LOAD_NEW, nn, style, 1 << 24);
      for (int j = 0; j < 45; j++) begin
        roll = $urandom_range(99);
        if (roll < 75 && nn > 0)
          push_req(CMD_COMPUTE, $urandom_range(0, nn - 1), $urandom, $urandom);
        else if (roll < 84)
          push_req(CMD_COMPUTE, $urandom_range(nn, 4095), $urandom, $urandom);
        else if (roll < 90)
          push_req(CMD_LOAD_OLD, $urandom_range(0, 15), $urandom, random_count());
        else if (roll < 94)
          push_req(CMD_LOAD_NEW, $urandom_range(0, 15), $urandom, 0);
        else
          push_req(CMD_IGNORED, $urandom_range(0, 4095), $urandom, $urandom);
      end
      wait_idle();
    end

    if (expected_bins.size() != 0)
      report_mismatch("results never returned", expected_bins.size(), 0);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/srov_pkg.sv
hw/rtl/srov_ctrl.sv
hw/rtl/srov_datapath.sv
hw/rtl/spectrum_rebin_overlap_top.sv
dv/tb.sv
